// File: hdl/pnps_pkg.sv
// Shared types and constants for the packed-nibble pixel span engine.
// No dependencies; used by the channel interfaces and the top level.
package pnps_pkg;

   localparam int MODE_W   = 2;
   localparam int X_W      = 9;
   localparam int Y_W      = 8;
   localparam int END_W    = 9;
   localparam int COLOR_W  = 12;
   localparam int NIBBLE_W = 4;
   localparam int BYTE_W   = 8;
   // nibble index of a pixel is 3 * column
   localparam int NIB_W    = $clog2(3 * (2 ** X_W - 1) + 1);

   localparam logic [BYTE_W-1:0] LOW_MASK  = 8'h0F;
   localparam logic [BYTE_W-1:0] HIGH_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] FULL_MASK = 8'hFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_DRAW  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_HSPAN = 2'd2,
      MODE_VSPAN = 2'd3
   } mode_type;

endpackage

// File: hdl/pnps_if.sv
// Valid/ready channel interfaces: command, result and config write.
// Depends on pnps_pkg.
interface pnps_req_if;
   import pnps_pkg::*;
   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [X_W-1:0]       x_coord;
   logic [Y_W-1:0]       y_coord;
   logic [END_W-1:0]     end_coord;
   logic [COLOR_W-1:0]   color;
   modport source (output valid, mode, x_coord, y_coord, end_coord, color, input ready);
   modport sink   (input valid, mode, x_coord, y_coord, end_coord, color, output ready);
endinterface

interface pnps_rsp_if;
   import pnps_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [COLOR_W-1:0]   pixel_value;
   logic                 empty_span;
   modport source (output valid, pixel_value, empty_span, input ready);
   modport sink   (input valid, pixel_value, empty_span, output ready);
endinterface

interface pnps_csr_if;
   logic valid;
   logic ready;
   logic raster_op;
   modport source (output valid, raster_op, input ready);
   modport sink   (input valid, raster_op, output ready);
endinterface

// File: hdl/pnps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pnps_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 2,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/packed_nibble_pixel_span_engine.sv
// Pixel draw/read and span fill over a packed RGB444 byte frame store.
// Each pixel passes through a read state and a write state; a reversed span goes straight
// to the output state. If the result register is full, the result waits in the output state.
// The next command is taken the cycle after the result is loaded.
// Each pixel is a read-modify-write of two adjacent bytes, split over an even and
// an odd byte bank, so both bytes are read in the read state and, for a draw, written in the write state.
// Reset is synchronous; afterwards both banks are zeroed, one entry of each per cycle,
// over all ceil(LINE_BYTES*LINES/2) entries with req_ch.ready low. Config writes always taken.
module packed_nibble_pixel_span_engine #(
   parameter int LINE_BYTES = 480,
   parameter int LINES      = 240
) (
   input  logic         clock,
   input  logic         reset,
   pnps_req_if.sink     req_ch,
   pnps_rsp_if.source   rsp_ch,
   pnps_csr_if.sink     csr_ch
);
   import pnps_pkg::*;

   localparam int STORE_BYTES = LINE_BYTES * LINES;
   localparam int BANK_DEPTH  = (STORE_BYTES + 1) / 2;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);
   localparam int ROW_MAX     = 2 ** END_W - 1;
   localparam int ADDR_W      = $clog2(ROW_MAX * LINE_BYTES + STORE_BYTES + 2 ** NIB_W);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RD    = 5'b00100,
      ST_WR    = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // control
   state_type            state_ff, state_in;
   logic [BANK_AW-1:0]   clr_ff, clr_in;
   logic                 raster_op_ff, raster_op_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // command and pixel walk
   mode_type             mode_ff, mode_in;
   logic [END_W-1:0]     pos_ff, pos_in;
   logic [END_W-1:0]     end_ff, end_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic [NIB_W-1:0]     nib_ff, nib_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic                 swap_ff, swap_in;
   logic                 ok_lo_ff, ok_lo_in;
   logic                 ok_hi_ff, ok_hi_in;
   logic [BANK_AW-1:0]   even_idx_ff, even_idx_in;
   logic [BANK_AW-1:0]   odd_idx_ff, odd_idx_in;
   logic [COLOR_W-1:0]   pend_value_ff, pend_value_in;
   logic                 pend_empty_ff, pend_empty_in;
   logic [COLOR_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   // datapath
   logic [ADDR_W-1:0]    a0, a0_half, even_full;
   logic [BYTE_W-1:0]    rd_even, rd_odd;
   logic [BYTE_W-1:0]    lo_b, hi_b, lo_v, hi_v;
   logic [BYTE_W-1:0]    d_lo, d_hi, m_lo, m_hi, new_lo, new_hi;
   logic [NIBBLE_W-1:0]  c_r, c_g, c_b;
   logic [COLOR_W-1:0]   value_calc;
   logic [BANK_AW-1:0]   rd_even_addr, rd_odd_addr;
   logic [BANK_AW-1:0]   wr_even_addr, wr_odd_addr;
   logic [BYTE_W-1:0]    wr_even_data, wr_odd_data;
   logic                 we_even, we_odd;
   logic                 draw, last_pixel, out_free, rsp_load, reversed;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pixel_value = rsp_value_ff;
   assign rsp_ch.empty_span  = rsp_empty_ff;

   // byte address of the pixel's first nibble; the second byte is the next one
   assign a0        = base_ff + ADDR_W'(nib_ff >> 1);
   assign a0_half   = a0 >> 1;
   assign even_full = a0_half + ADDR_W'(a0[0]);
   assign rd_odd_addr  = a0_half[BANK_AW-1:0];
   assign rd_even_addr = even_full[BANK_AW-1:0];

   assign lo_b = swap_ff ? rd_odd : rd_even;
   assign hi_b = swap_ff ? rd_even : rd_odd;
   assign lo_v = ok_lo_ff ? lo_b : '0;
   assign hi_v = ok_hi_ff ? hi_b : '0;

   assign c_r = color_ff[3*NIBBLE_W-1:2*NIBBLE_W];
   assign c_g = color_ff[2*NIBBLE_W-1:NIBBLE_W];
   assign c_b = color_ff[NIBBLE_W-1:0];

   always_comb begin
      if (!nib_ff[0]) begin
         d_lo = {c_g, c_r};
         m_lo = FULL_MASK;
         d_hi = {{NIBBLE_W{1'b0}}, c_b};
         m_hi = LOW_MASK;
         value_calc = {lo_v[3:0], lo_v[7:4], hi_v[3:0]};
      end else begin
         d_lo = {c_r, {NIBBLE_W{1'b0}}};
         m_lo = HIGH_MASK;
         d_hi = {c_b, c_g};
         m_hi = FULL_MASK;
         value_calc = {lo_v[7:4], hi_v[3:0], hi_v[7:4]};
      end
      new_lo = raster_op_ff ? (lo_b ^ d_lo) : ((lo_b & ~m_lo) | d_lo);
      new_hi = raster_op_ff ? (hi_b ^ d_hi) : ((hi_b & ~m_hi) | d_hi);
   end

   assign draw       = (mode_ff != MODE_READ);
   assign last_pixel = (mode_ff == MODE_DRAW) || (mode_ff == MODE_READ) ||
                       (pos_ff == end_ff);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign reversed   = ((req_ch.mode == MODE_HSPAN) && (req_ch.end_coord < req_ch.x_coord)) ||
                       ((req_ch.mode == MODE_VSPAN) &&
                        (req_ch.end_coord < END_W'(req_ch.y_coord)));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      raster_op_in  = (csr_ch.valid && csr_ch.ready) ? csr_ch.raster_op : raster_op_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      end_in        = end_ff;
      color_in      = color_ff;
      nib_in        = nib_ff;
      base_in       = base_ff;
      swap_in       = swap_ff;
      ok_lo_in      = ok_lo_ff;
      ok_hi_in      = ok_hi_ff;
      even_idx_in   = even_idx_ff;
      odd_idx_in    = odd_idx_ff;
      pend_value_in = pend_value_ff;
      pend_empty_in = pend_empty_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_empty_in  = rsp_empty_ff;
      we_even       = 1'b0;
      we_odd        = 1'b0;
      wr_even_addr  = even_idx_ff;
      wr_odd_addr   = odd_idx_ff;
      wr_even_data  = swap_ff ? new_hi : new_lo;
      wr_odd_data   = swap_ff ? new_lo : new_hi;

      unique case (state_ff)
         ST_CLEAR: begin
            we_even      = 1'b1;
            we_odd       = 1'b1;
            wr_even_addr = clr_ff;
            wr_odd_addr  = clr_ff;
            wr_even_data = '0;
            wr_odd_data  = '0;
            if (clr_ff == BANK_AW'(BANK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + BANK_AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in  = req_ch.mode;
               end_in   = req_ch.end_coord;
               color_in = req_ch.color;
               nib_in   = NIB_W'(req_ch.x_coord) + (NIB_W'(req_ch.x_coord) << 1);
               base_in  = ADDR_W'(req_ch.y_coord) * ADDR_W'(LINE_BYTES);
               pos_in   = (req_ch.mode == MODE_VSPAN) ? END_W'(req_ch.y_coord)
                                                      : END_W'(req_ch.x_coord);
               if (reversed) begin
                  pend_value_in = '0;
                  pend_empty_in = 1'b1;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            swap_in     = a0[0];
            ok_lo_in    = (a0 < ADDR_W'(STORE_BYTES));
            ok_hi_in    = (a0 < ADDR_W'(STORE_BYTES - 1));
            even_idx_in = rd_even_addr;
            odd_idx_in  = rd_odd_addr;
            state_in    = ST_WR;
         end
         ST_WR: begin
            we_even = draw && (swap_ff ? ok_hi_ff : ok_lo_ff);
            we_odd  = draw && (swap_ff ? ok_lo_ff : ok_hi_ff);
            if (last_pixel) begin
               if (out_free) begin
                  rsp_load     = 1'b1;
                  rsp_value_in = draw ? '0 : value_calc;
                  rsp_empty_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  pend_value_in = draw ? '0 : value_calc;
                  pend_empty_in = 1'b0;
                  state_in      = ST_OUT;
               end
            end else begin
               pos_in = pos_ff + END_W'(1);
               if (mode_ff == MODE_HSPAN) begin
                  nib_in = nib_ff + NIB_W'(3);
               end else begin
                  base_in = base_ff + ADDR_W'(LINE_BYTES);
               end
               state_in = ST_RD;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = pend_value_ff;
               rsp_empty_in = pend_empty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         raster_op_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         raster_op_ff <= raster_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      end_ff        <= end_in;
      color_ff      <= color_in;
      nib_ff        <= nib_in;
      base_ff       <= base_in;
      swap_ff       <= swap_in;
      ok_lo_ff      <= ok_lo_in;
      ok_hi_ff      <= ok_hi_in;
      even_idx_ff   <= even_idx_in;
      odd_idx_ff    <= odd_idx_in;
      pend_value_ff <= pend_value_in;
      pend_empty_ff <= pend_empty_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   pnps_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (we_even),
      .wr_addr (wr_even_addr),
      .wr_data (wr_even_data),
      .rd_addr (rd_even_addr),
      .rd_data (rd_even)
   );

   pnps_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (we_odd),
      .wr_addr (wr_odd_addr),
      .wr_data (wr_odd_data),
      .rd_addr (rd_odd_addr),
      .rd_data (rd_odd)
   );

   // a read cycle is always followed by its write cycle
   a_rd_then_wr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |=> (state_ff == ST_WR))
      else $error("read cycle not followed by write cycle");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      (we_even || we_odd) |-> ((state_ff == ST_CLEAR) || (state_ff == ST_WR)))
      else $error("bank write outside clear or write cycle");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WR) && (mode_ff == MODE_READ)) |-> (!we_even && !we_odd))
      else $error("pixel read modified the store");

   a_reversed_span: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && reversed) |=> (state_ff == ST_OUT))
      else $error("reversed span did not go straight to result");

endmodule
